[sv/lcfp_pkg.sv]
// ----------------------------------------------------------------------------
// lcfp_pkg
// Shared types and constants of the LED command frame parser.
// ----------------------------------------------------------------------------
package lcfp_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] CFG_START_WORD     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_STOP_WORD      = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_RESERVED_VALUE = 2'd2;

	localparam logic [15:0] START_WORD_RST     = 16'hFEFD;
	localparam logic [15:0] STOP_WORD_RST      = 16'hFDFE;
	localparam logic [7:0]  RESERVED_VALUE_RST = 8'h00;

	localparam logic [7:0] TYPE_ON_OFF = 8'h01;
	localparam logic [7:0] TYPE_BLINK  = 8'h02;
	localparam logic [7:0] TYPE_PWM    = 8'h03;

	localparam logic [7:0] PAYLOAD_OFF = 8'h00;
	localparam logic [7:0] PAYLOAD_ON  = 8'h01;

	localparam logic [1:0] MODE_OFF   = 2'd0;
	localparam logic [1:0] MODE_ON    = 2'd1;
	localparam logic [1:0] MODE_BLINK = 2'd2;
	localparam logic [1:0] MODE_PWM   = 2'd3;

	// byte plus its matches against the configured marker bytes
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       is_start_hi;
		logic       is_start_lo;
		logic       is_resv;
		logic       is_stop_hi;
		logic       is_stop_lo;
	} cls_t;

	typedef struct packed {
		logic [7:0]  echo_byte;
		logic        payload_valid;
		logic [15:0] payload_index;
		logic        frame_dropped;
		logic        frame_done;
		logic [7:0]  frame_type;
		logic        mode_valid;
		logic [1:0]  led_mode;
	} res_t;

	typedef enum logic [8:0] {
		PH_IDLE     = 9'b000000001,
		PH_START2   = 9'b000000010,
		PH_LEN_HI   = 9'b000000100,
		PH_LEN_LO   = 9'b000001000,
		PH_TYPE     = 9'b000010000,
		PH_PAYLOAD  = 9'b000100000,
		PH_RESERVED = 9'b001000000,
		PH_STOP1    = 9'b010000000,
		PH_STOP2    = 9'b100000000
	} phase_t;

endpackage

[sv/lcfp_fifo.sv]
// ----------------------------------------------------------------------------
// lcfp_fifo
// Small synchronous queue of flops; DEPTH must be a power of two, at least 2, which is not checked here.
// ----------------------------------------------------------------------------
module lcfp_fifo #(
	parameter int  DEPTH  = 2,
	parameter type item_t = logic
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wdata,
	output logic  full,
	input  logic  pop,
	output item_t rdata,
	output logic  empty
);

	localparam int AW = $clog2(DEPTH);

	item_t         mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;
	logic          push_ok;
	logic          pop_ok;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign push_ok = push & ~full;
	assign pop_ok  = pop & ~empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + (AW+1)'(1);
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - (AW+1)'(1);
			end
		end
	end

endmodule

[sv/lcfp_front.sv]
// ----------------------------------------------------------------------------
// lcfp_front
// Holds the configuration registers and tags each received byte with its
// matches against the start, stop and reserved bytes.
// ----------------------------------------------------------------------------
module lcfp_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [lcfp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lcfp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [7:0]                       rx_byte,
	output lcfp_pkg::cls_t                   cls
);

	logic [15:0] start_word_q;
	logic [15:0] stop_word_q;
	logic [7:0]  resv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_word_q <= lcfp_pkg::START_WORD_RST;
			stop_word_q  <= lcfp_pkg::STOP_WORD_RST;
			resv_q       <= lcfp_pkg::RESERVED_VALUE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lcfp_pkg::CFG_START_WORD:     start_word_q <= cfg_data;
				lcfp_pkg::CFG_STOP_WORD:      stop_word_q  <= cfg_data;
				lcfp_pkg::CFG_RESERVED_VALUE: resv_q       <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cls.rx_byte     = rx_byte;
		cls.is_start_hi = (rx_byte == start_word_q[15:8]);
		cls.is_start_lo = (rx_byte == start_word_q[7:0]);
		cls.is_resv     = (rx_byte == resv_q);
		cls.is_stop_hi  = (rx_byte == stop_word_q[15:8]);
		cls.is_stop_lo  = (rx_byte == stop_word_q[7:0]);
	end

endmodule

[sv/lcfp_parser.sv]
// ----------------------------------------------------------------------------
// lcfp_parser
// Frame FSM: a tagged byte per cycle in, a result out, unless a queue stalls.
// ----------------------------------------------------------------------------
module lcfp_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_empty,
	input  lcfp_pkg::cls_t in_item,
	output logic           in_pop,
	input  logic           out_full,
	output logic           out_push,
	output lcfp_pkg::res_t out_item
);

	lcfp_pkg::phase_t phase_q, phase_d;
	logic [15:0] len_q, len_d;
	logic [15:0] cnt_q, cnt_d;
	logic [7:0]  type_q, type_d;
	logic [7:0]  first_q, first_d;
	logic [15:0] cnt_inc;
	logic        step;

	assign step     = ~in_empty & ~out_full;
	assign in_pop   = step;
	assign out_push = step;
	assign cnt_inc  = cnt_q + 16'd1;

	always_comb begin
		phase_d  = phase_q;
		len_d    = len_q;
		cnt_d    = cnt_q;
		type_d   = type_q;
		first_d  = first_q;
		out_item = '0;
		out_item.echo_byte = in_item.rx_byte;

		unique case (phase_q)
			lcfp_pkg::PH_START2: begin
				if (in_item.is_start_lo) begin
					phase_d = lcfp_pkg::PH_LEN_HI;
				end else begin
					out_item.frame_dropped = 1'b1;
					phase_d = lcfp_pkg::PH_IDLE;
					len_d = '0; cnt_d = '0; type_d = '0; first_d = '0;
				end
			end
			lcfp_pkg::PH_LEN_HI: begin
				len_d   = {in_item.rx_byte, 8'h00};
				phase_d = lcfp_pkg::PH_LEN_LO;
			end
			lcfp_pkg::PH_LEN_LO: begin
				len_d   = {len_q[15:8], in_item.rx_byte};
				phase_d = lcfp_pkg::PH_TYPE;
			end
			lcfp_pkg::PH_TYPE: begin
				type_d  = in_item.rx_byte;
				cnt_d   = '0;
				phase_d = (len_q == '0) ? lcfp_pkg::PH_RESERVED : lcfp_pkg::PH_PAYLOAD;
			end
			lcfp_pkg::PH_PAYLOAD: begin
				out_item.payload_valid = 1'b1;
				out_item.payload_index = cnt_q;
				if (cnt_q == '0) begin
					first_d = in_item.rx_byte;
				end
				if (cnt_inc == len_q) begin
					cnt_d   = '0;
					phase_d = lcfp_pkg::PH_RESERVED;
				end else begin
					cnt_d = cnt_inc;
				end
			end
			lcfp_pkg::PH_RESERVED: begin
				if (in_item.is_resv) begin
					phase_d = lcfp_pkg::PH_STOP1;
				end else begin
					out_item.frame_dropped = 1'b1;
					phase_d = lcfp_pkg::PH_IDLE;
					len_d = '0; cnt_d = '0; type_d = '0; first_d = '0;
				end
			end
			lcfp_pkg::PH_STOP1: begin
				if (in_item.is_stop_hi) begin
					phase_d = lcfp_pkg::PH_STOP2;
				end else begin
					out_item.frame_dropped = 1'b1;
					phase_d = lcfp_pkg::PH_IDLE;
					len_d = '0; cnt_d = '0; type_d = '0; first_d = '0;
				end
			end
			lcfp_pkg::PH_STOP2: begin
				if (in_item.is_stop_lo) begin
					out_item.frame_done = 1'b1;
					out_item.frame_type = type_q;
					priority if (type_q == lcfp_pkg::TYPE_ON_OFF) begin
						if (len_q != '0 && first_q == lcfp_pkg::PAYLOAD_OFF) begin
							out_item.mode_valid = 1'b1;
							out_item.led_mode   = lcfp_pkg::MODE_OFF;
						end else if (len_q != '0 && first_q == lcfp_pkg::PAYLOAD_ON) begin
							out_item.mode_valid = 1'b1;
							out_item.led_mode   = lcfp_pkg::MODE_ON;
						end
					end else if (type_q == lcfp_pkg::TYPE_BLINK) begin
						out_item.mode_valid = 1'b1;
						out_item.led_mode   = lcfp_pkg::MODE_BLINK;
					end else if (type_q == lcfp_pkg::TYPE_PWM) begin
						out_item.mode_valid = 1'b1;
						out_item.led_mode   = lcfp_pkg::MODE_PWM;
					end
				end else begin
					out_item.frame_dropped = 1'b1;
				end
				phase_d = lcfp_pkg::PH_IDLE;
				len_d = '0; cnt_d = '0; type_d = '0; first_d = '0;
			end
			default: begin
				len_d = '0; cnt_d = '0; type_d = '0; first_d = '0;
				phase_d = in_item.is_start_hi ? lcfp_pkg::PH_START2 : lcfp_pkg::PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lcfp_pkg::PH_IDLE;
			len_q   <= '0;
			cnt_q   <= '0;
			type_q  <= '0;
			first_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			type_q  <= type_d;
			first_q <= first_d;
		end
	end

endmodule

[sv/led_command_frame_parser_top.sv]
// ----------------------------------------------------------------------------
// led_command_frame_parser_top
// Serial byte frame parser selecting an LED mode.
//
// channel  direction  handshake               payload
// input    in         push / full             rx_byte
// result   out        empty / pop             echo_byte .. led_mode
// config   in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item per cycle sustained while the result queue has room; a pushed byte
// passes the tag queue and the parser step before it can be popped.
// Reset empties both queues, sets the parser idle and restores the defaults.
// A full result queue stalls the parser; the tag queue keeps taking items
// until it fills too. cfg_ready is always high.
// ----------------------------------------------------------------------------
module led_command_frame_parser_top #(
	parameter int MID_DEPTH = 2,
	parameter int OUT_DEPTH = 2
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [7:0]                       rx_byte,
	output logic                             empty,
	input  logic                             pop,
	output logic [7:0]                       echo_byte,
	output logic                             payload_valid,
	output logic [15:0]                      payload_index,
	output logic                             frame_dropped,
	output logic                             frame_done,
	output logic [7:0]                       frame_type,
	output logic                             mode_valid,
	output logic [1:0]                       led_mode,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lcfp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lcfp_pkg::CFG_DATA_W-1:0]  cfg_data
);

	lcfp_pkg::cls_t cls_in;
	lcfp_pkg::cls_t cls_mid;
	lcfp_pkg::res_t res_in;
	lcfp_pkg::res_t res_out;
	logic           mid_empty;
	logic           mid_pop;
	logic           out_full;
	logic           out_push;

	assign cfg_ready = 1'b1;

	lcfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx_byte   (rx_byte),
		.cls       (cls_in)
	);

	lcfp_fifo #(
		.DEPTH  (MID_DEPTH),
		.item_t (lcfp_pkg::cls_t)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cls_in),
		.full   (full),
		.pop    (mid_pop),
		.rdata  (cls_mid),
		.empty  (mid_empty)
	);

	lcfp_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_empty (mid_empty),
		.in_item  (cls_mid),
		.in_pop   (mid_pop),
		.out_full (out_full),
		.out_push (out_push),
		.out_item (res_in)
	);

	lcfp_fifo #(
		.DEPTH  (OUT_DEPTH),
		.item_t (lcfp_pkg::res_t)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (res_in),
		.full   (out_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign echo_byte     = res_out.echo_byte;
	assign payload_valid = res_out.payload_valid;
	assign payload_index = res_out.payload_index;
	assign frame_dropped = res_out.frame_dropped;
	assign frame_done    = res_out.frame_done;
	assign frame_type    = res_out.frame_type;
	assign mode_valid    = res_out.mode_valid;
	assign led_mode      = res_out.led_mode;

endmodule

[sim/led_command_frame_parser_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_command_frame_parser_top_test
// Self-checking bench for the LED command frame parser.
//
// Bytes are pushed through the input queue and every popped result is compared
// field by field with a behavioral copy of the parser, or with the expected
// result given by a directed table entry. A short table of directed bytes is run
// first, then random frames mixed with stray bytes and broken frames under several
// marker and reserved byte settings. Both queue sides stall at random, except in one phase.
// ----------------------------------------------------------------------------
module led_command_frame_parser_top_test;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned PHASE_ITEMS = 60;
	localparam int unsigned TAIL_CYCLES = 8;

	localparam logic [lcfp_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

	localparam logic [7:0] SOF_HI = lcfp_pkg::START_WORD_RST[15:8];
	localparam logic [7:0] SOF_LO = lcfp_pkg::START_WORD_RST[7:0];
	localparam logic [7:0] EOF_HI = lcfp_pkg::STOP_WORD_RST[15:8];
	localparam logic [7:0] EOF_LO = lcfp_pkg::STOP_WORD_RST[7:0];
	localparam logic [7:0] RESV   = lcfp_pkg::RESERVED_VALUE_RST;

	typedef struct packed {
		logic [7:0]     b;
		logic           given;
		lcfp_pkg::res_t res;
	} step_t;

	localparam step_t DIR_TABLE [26] = '{
		'{8'hFF, 1'b1, lcfp_pkg::res_t'{8'hFF, 1'b0, 16'd0, 1'b0, 1'b0, 8'd0, 1'b0,
			lcfp_pkg::MODE_OFF}},
		'{SOF_HI, 1'b1, lcfp_pkg::res_t'{SOF_HI, 1'b0, 16'd0, 1'b0, 1'b0, 8'd0, 1'b0,
			lcfp_pkg::MODE_OFF}},
		'{8'h00, 1'b1, lcfp_pkg::res_t'{8'h00, 1'b0, 16'd0, 1'b1, 1'b0, 8'd0, 1'b0,
			lcfp_pkg::MODE_OFF}},
		'{SOF_HI,                1'b0, '0},
		'{SOF_LO,                1'b0, '0},
		'{8'h00,                 1'b0, '0},
		'{8'h01,                 1'b0, '0},
		'{lcfp_pkg::TYPE_ON_OFF, 1'b0, '0},
		'{lcfp_pkg::PAYLOAD_ON,  1'b0, '0},
		'{RESV,                  1'b0, '0},
		'{EOF_HI,                1'b0, '0},
		'{EOF_LO, 1'b1, lcfp_pkg::res_t'{EOF_LO, 1'b0, 16'd0, 1'b0, 1'b1,
			lcfp_pkg::TYPE_ON_OFF, 1'b1, lcfp_pkg::MODE_ON}},
		'{SOF_HI,                1'b0, '0},
		'{SOF_LO,                1'b0, '0},
		'{8'h00,                 1'b0, '0},
		'{8'h00,                 1'b0, '0},
		'{lcfp_pkg::TYPE_BLINK,  1'b0, '0},
		'{RESV,                  1'b0, '0},
		'{EOF_HI,                1'b0, '0},
		'{EOF_LO, 1'b1, lcfp_pkg::res_t'{EOF_LO, 1'b0, 16'd0, 1'b0, 1'b1,
			lcfp_pkg::TYPE_BLINK, 1'b1, lcfp_pkg::MODE_BLINK}},
		'{SOF_HI,                1'b0, '0},
		'{SOF_LO,                1'b0, '0},
		'{8'h00,                 1'b0, '0},
		'{8'h00,                 1'b0, '0},
		'{lcfp_pkg::TYPE_PWM,    1'b0, '0},
		'{8'hFF, 1'b1, lcfp_pkg::res_t'{8'hFF, 1'b0, 16'd0, 1'b1, 1'b0, 8'd0, 1'b0,
			lcfp_pkg::MODE_OFF}}
	};

	logic                             clk;
	logic                             arst_n;
	logic                             push;
	logic                             full;
	logic [7:0]                       rx_byte;
	logic                             empty;
	logic                             pop;
	logic [7:0]                       echo_byte;
	logic                             payload_valid;
	logic [15:0]                      payload_index;
	logic                             frame_dropped;
	logic                             frame_done;
	logic [7:0]                       frame_type;
	logic                             mode_valid;
	logic [1:0]                       led_mode;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [lcfp_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [lcfp_pkg::CFG_DATA_W-1:0]  cfg_data;

	// tags riding along with each pushed byte
	logic           tag_given;
	lcfp_pkg::res_t tag_res;

	logic           no_idle;
	int unsigned    pop_stall;
	int unsigned    cycle_cnt;
	int unsigned    fail_cnt;
	int unsigned    sent_cnt;
	lcfp_pkg::res_t frame_results [$];

	// parser copy used for prediction
	logic [15:0]      prs_start = lcfp_pkg::START_WORD_RST;
	logic [15:0]      prs_stop  = lcfp_pkg::STOP_WORD_RST;
	logic [7:0]       prs_resv  = lcfp_pkg::RESERVED_VALUE_RST;
	lcfp_pkg::phase_t prs_phase = lcfp_pkg::PH_IDLE;
	logic [15:0]      prs_len   = '0;
	logic [15:0]      prs_count = '0;
	logic [7:0]       prs_type  = '0;
	logic [7:0]       prs_first = '0;

	// settings the frame builder uses
	logic [15:0] gen_start = lcfp_pkg::START_WORD_RST;
	logic [15:0] gen_stop  = lcfp_pkg::STOP_WORD_RST;
	logic [7:0]  gen_resv  = lcfp_pkg::RESERVED_VALUE_RST;

	led_command_frame_parser_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.rx_byte       (rx_byte),
		.empty         (empty),
		.pop           (pop),
		.echo_byte     (echo_byte),
		.payload_valid (payload_valid),
		.payload_index (payload_index),
		.frame_dropped (frame_dropped),
		.frame_done    (frame_done),
		.frame_type    (frame_type),
		.mode_valid    (mode_valid),
		.led_mode      (led_mode),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_frame();
		prs_phase = lcfp_pkg::PH_IDLE;
		prs_len   = '0;
		prs_count = '0;
		prs_type  = '0;
		prs_first = '0;
	endfunction

	function automatic lcfp_pkg::res_t parse_byte(logic [7:0] b);
		lcfp_pkg::res_t r;
		r = '0;
		r.echo_byte = b;
		case (prs_phase)
			lcfp_pkg::PH_START2: begin
				if (b == prs_start[7:0]) begin
					prs_phase = lcfp_pkg::PH_LEN_HI;
				end else begin
					r.frame_dropped = 1'b1;
					clear_frame();
				end
			end
			lcfp_pkg::PH_LEN_HI: begin
				prs_len   = {b, 8'h00};
				prs_phase = lcfp_pkg::PH_LEN_LO;
			end
			lcfp_pkg::PH_LEN_LO: begin
				prs_len[7:0] = b;
				prs_phase    = lcfp_pkg::PH_TYPE;
			end
			lcfp_pkg::PH_TYPE: begin
				prs_type  = b;
				prs_count = '0;
				prs_phase = (prs_len == 16'd0) ? lcfp_pkg::PH_RESERVED : lcfp_pkg::PH_PAYLOAD;
			end
			lcfp_pkg::PH_PAYLOAD: begin
				r.payload_valid = 1'b1;
				r.payload_index = prs_count;
				if (prs_count == 16'd0) begin
					prs_first = b;
				end
				prs_count = prs_count + 16'd1;
				if (prs_count == prs_len) begin
					prs_count = '0;
					prs_phase = lcfp_pkg::PH_RESERVED;
				end
			end
			lcfp_pkg::PH_RESERVED: begin
				if (b == prs_resv) begin
					prs_phase = lcfp_pkg::PH_STOP1;
				end else begin
					r.frame_dropped = 1'b1;
					clear_frame();
				end
			end
			lcfp_pkg::PH_STOP1: begin
				if (b == prs_stop[15:8]) begin
					prs_phase = lcfp_pkg::PH_STOP2;
				end else begin
					r.frame_dropped = 1'b1;
					clear_frame();
				end
			end
			lcfp_pkg::PH_STOP2: begin
				if (b == prs_stop[7:0]) begin
					r.frame_done = 1'b1;
					r.frame_type = prs_type;
					case (prs_type)
						lcfp_pkg::TYPE_ON_OFF: begin
							if (prs_len != 16'd0 && prs_first == lcfp_pkg::PAYLOAD_OFF) begin
								r.mode_valid = 1'b1;
								r.led_mode   = lcfp_pkg::MODE_OFF;
							end else if (prs_len != 16'd0 && prs_first == lcfp_pkg::PAYLOAD_ON) begin
								r.mode_valid = 1'b1;
								r.led_mode   = lcfp_pkg::MODE_ON;
							end
						end
						lcfp_pkg::TYPE_BLINK: begin
							r.mode_valid = 1'b1;
							r.led_mode   = lcfp_pkg::MODE_BLINK;
						end
						lcfp_pkg::TYPE_PWM: begin
							r.mode_valid = 1'b1;
							r.led_mode   = lcfp_pkg::MODE_PWM;
						end
						default: ;
					endcase
				end else begin
					r.frame_dropped = 1'b1;
				end
				clear_frame();
			end
			default: begin
				clear_frame();
				if (b == prs_start[15:8]) begin
					prs_phase = lcfp_pkg::PH_START2;
				end
			end
		endcase
		return r;
	endfunction

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_cnt++;
		end
	endtask

	// mostly back to back, sometimes a few cycles, rarely a long pause
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		lcfp_pkg::res_t want;
		lcfp_pkg::res_t got;
		if (arst_n) begin
			if (pop && !empty) begin
				got = '{echo_byte, payload_valid, payload_index, frame_dropped, frame_done,
					frame_type, mode_valid, led_mode};
				if (frame_results.size() == 0) begin
					$error("result with no item pending: echo_byte 0x%0h", echo_byte);
					fail_cnt++;
				end else begin
					want = frame_results.pop_front();
					check_field("echo_byte", 16'(want.echo_byte), 16'(got.echo_byte));
					check_field("payload_valid", 16'(want.payload_valid),
						16'(got.payload_valid));
					check_field("payload_index", want.payload_index, got.payload_index);
					check_field("frame_dropped", 16'(want.frame_dropped),
						16'(got.frame_dropped));
					check_field("frame_done", 16'(want.frame_done), 16'(got.frame_done));
					check_field("frame_type", 16'(want.frame_type), 16'(got.frame_type));
					check_field("mode_valid", 16'(want.mode_valid), 16'(got.mode_valid));
					check_field("led_mode", 16'(want.led_mode), 16'(got.led_mode));
				end
			end
			if (push && !full) begin
				want = parse_byte(rx_byte);
				frame_results.push_back(tag_given ? tag_res : want);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					lcfp_pkg::CFG_START_WORD:     prs_start = cfg_data;
					lcfp_pkg::CFG_STOP_WORD:      prs_stop  = cfg_data;
					lcfp_pkg::CFG_RESERVED_VALUE: prs_resv  = cfg_data[7:0];
					default: ;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (pop_stall != 0) begin
			pop <= 1'b0;
			pop_stall <= pop_stall - 1;
		end else begin
			pop <= 1'b1;
			if (!no_idle) begin
				pop_stall <= pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_byte(logic [7:0] b, logic given = 1'b0, lcfp_pkg::res_t typed = '0);
		int unsigned gap;
		push      <= 1'b1;
		rx_byte   <= b;
		tag_given <= given;
		tag_res   <= typed;
		do @(posedge clk); while (full);
		sent_cnt++;
		gap = no_idle ? 0 : pick_gap();
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		push <= 1'b0;
		@(posedge clk);
		while (frame_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [lcfp_pkg::CFG_INDEX_W-1:0] idx,
			logic [lcfp_pkg::CFG_DATA_W-1:0] data);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			lcfp_pkg::CFG_START_WORD:     gen_start = data;
			lcfp_pkg::CFG_STOP_WORD:      gen_stop  = data;
			lcfp_pkg::CFG_RESERVED_VALUE: gen_resv  = data[7:0];
			default: ;
		endcase
	endtask

	// one frame with random content; some are broken on purpose
	task automatic send_frame(logic [15:0] len);
		logic [7:0]  ftype;
		logic [7:0]  pl0;
		int unsigned flaw;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 3) ftype = lcfp_pkg::TYPE_ON_OFF;
		else if (pick < 5) ftype = lcfp_pkg::TYPE_BLINK;
		else if (pick < 7) ftype = lcfp_pkg::TYPE_PWM;
		else ftype = 8'($urandom_range(0, 255));
		pick = $urandom_range(0, 2);
		pl0 = 8'($urandom_range(0, 255));
		if (pick == 0) pl0 = lcfp_pkg::PAYLOAD_OFF;
		else if (pick == 1) pl0 = lcfp_pkg::PAYLOAD_ON;
		flaw = $urandom_range(0, 11);
		send_byte(gen_start[15:8]);
		if (flaw == 0) begin
			send_byte(~gen_start[7:0]);
			return;
		end
		send_byte(gen_start[7:0]);
		send_byte(len[15:8]);
		send_byte(len[7:0]);
		send_byte(ftype);
		for (int i = 0; i < len; i++) begin
			send_byte((i == 0) ? pl0 : 8'($urandom_range(0, 255)));
			if (flaw == 4 && i == len / 2) return;
		end
		if (flaw == 1) begin
			send_byte(~gen_resv);
			return;
		end
		send_byte(gen_resv);
		if (flaw == 2) begin
			send_byte(~gen_stop[15:8]);
			return;
		end
		send_byte(gen_stop[15:8]);
		send_byte((flaw == 3) ? ~gen_stop[7:0] : gen_stop[7:0]);
	endtask

	function automatic logic [15:0] pick_len();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 5) return 16'($urandom_range(0, 3));
		if (r < 9) return 16'($urandom_range(4, 20));
		return 16'($urandom_range(21, 64));
	endfunction

	initial begin
		int unsigned target;
		arst_n    = 1'b0;
		push      = 1'b0;
		rx_byte   = '0;
		pop       = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = lcfp_pkg::CFG_START_WORD;
		cfg_data  = '0;
		tag_given = 1'b0;
		tag_res   = '0;
		no_idle   = 1'b0;
		pop_stall = 0;
		cycle_cnt = 0;
		fail_cnt  = 0;
		sent_cnt  = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_TABLE[i]) begin
			send_byte(DIR_TABLE[i].b, DIR_TABLE[i].given, DIR_TABLE[i].res);
		end

		for (int p = 0; p < 6; p++) begin
			case (p)
				1: begin
					write_reg(lcfp_pkg::CFG_START_WORD, 16'h0000);
					write_reg(lcfp_pkg::CFG_STOP_WORD, 16'hFFFF);
					write_reg(lcfp_pkg::CFG_RESERVED_VALUE, 16'h00FF);
				end
				2: begin
					write_reg(lcfp_pkg::CFG_START_WORD, 16'hFFFF);
					write_reg(lcfp_pkg::CFG_STOP_WORD, 16'h0000);
					write_reg(lcfp_pkg::CFG_RESERVED_VALUE, 16'hFF00);
					write_reg(CFG_UNUSED, 16'hFFFF);
				end
				3, 4: begin
					write_reg(lcfp_pkg::CFG_START_WORD, 16'($urandom_range(0, 65535)));
					write_reg(lcfp_pkg::CFG_STOP_WORD, 16'($urandom_range(0, 65535)));
					write_reg(lcfp_pkg::CFG_RESERVED_VALUE, 16'($urandom_range(0, 65535)));
				end
				5: begin
					write_reg(lcfp_pkg::CFG_START_WORD, lcfp_pkg::START_WORD_RST);
					write_reg(lcfp_pkg::CFG_STOP_WORD, lcfp_pkg::STOP_WORD_RST);
					write_reg(lcfp_pkg::CFG_RESERVED_VALUE,
						{8'h00, lcfp_pkg::RESERVED_VALUE_RST});
				end
				default: ;
			endcase
			no_idle <= (p == 3);
			if (p == 3) begin
				send_frame(16'($urandom_range(256, 300)));
			end
			target = sent_cnt + PHASE_ITEMS;
			while (sent_cnt < target) begin
				if ($urandom_range(0, 149) == 0) begin
					drain_results();
				end
				if ($urandom_range(0, 4) != 0) begin
					send_frame(pick_len());
				end else begin
					repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
				end
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
